>>> sv/multi_stack_shared_array_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the multi-stack shared array unit.
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_ARRAY_UNIT_ASSERT_SVH
`define MULTI_STACK_SHARED_ARRAY_UNIT_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define MSSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define MSSA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `MSSA_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

>>> sv/mssa_pkg.sv
// ----------------------------------------------------------------------------
// Multi-stack shared array package
// Sizes, codes and control types shared by the multi-stack shared array unit.
// ----------------------------------------------------------------------------
package mssa_pkg;

  localparam int NUM_STACKS   = 3;
  localparam int MAX_CAPACITY = 64;
  localparam int DATA_WIDTH   = 32;

  localparam int STORE_DEPTH = NUM_STACKS * MAX_CAPACITY;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_CAPACITY + 1);
  localparam int SIDX_W      = $clog2(NUM_STACKS);

  localparam int OP_W     = 2;
  localparam int SEL_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

>>> sv/mssa_dp.sv
// ----------------------------------------------------------------------------
// Multi-stack datapath
// Holds the capacity register, the fill counts, the shared entry memory and
// the result register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
`include "multi_stack_shared_array_unit_assert.svh"

module mssa_dp
  import mssa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                cfg_valid_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic [SEL_W-1:0]    sel_i,
  input  logic [VAL_W-1:0]    val_i,
  output logic [VAL_W-1:0]    read_value_o,
  output logic [STATUS_W-1:0] status_o
);

  logic [CNT_W-1:0]      cap_q, cap_d;
  logic [CNT_W-1:0]      cnt_q [NUM_STACKS];
  op_e                   op_q;
  logic [SEL_W-1:0]      sel_q;
  logic [VAL_W-1:0]      val_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  rd_hit_q, rd_hit_d;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [VAL_W-1:0]      out_data_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [DATA_WIDTH-1:0] mem_q [STORE_DEPTH];

  logic                  sel_ok;
  logic [SIDX_W-1:0]     idx;
  logic [CNT_W-1:0]      cnt_cur;
  logic [ADDR_W-1:0]     base;
  logic [ADDR_W-1:0]     addr;
  logic                  wr_en;
  logic                  rd_en;
  logic                  cnt_inc;
  logic                  cnt_dec;

  always_comb begin
    if (cfg_data_i == '0) begin
      cap_d = CNT_W'(1);
    end else if (int'(cfg_data_i) > MAX_CAPACITY) begin
      cap_d = CNT_W'(MAX_CAPACITY);
    end else begin
      cap_d = CNT_W'(cfg_data_i);
    end
  end

  assign sel_ok  = int'(sel_q) < NUM_STACKS;
  assign idx     = SIDX_W'(sel_q);
  assign cnt_cur = sel_ok ? cnt_q[idx] : '0;
  assign base    = ADDR_W'(ADDR_W'(sel_q) * ADDR_W'(cap_q));

  always_comb begin
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    rd_hit_d = 1'b0;
    status_d = STAT_DONE;
    addr     = base + ADDR_W'(cnt_cur);
    case (op_q)
      OP_PUSH: begin
        if (sel_ok && (cnt_cur < cap_q)) begin
          wr_en   = cmd_i.exec;
          cnt_inc = cmd_i.exec;
        end else begin
          status_d = STAT_FULL;
        end
      end
      OP_POP, OP_PEEK: begin
        addr = base + ADDR_W'(cnt_cur) - ADDR_W'(1);
        if (sel_ok && (cnt_cur != '0)) begin
          rd_en    = cmd_i.exec;
          rd_hit_d = 1'b1;
          cnt_dec  = cmd_i.exec && (op_q == OP_POP);
        end else begin
          status_d = STAT_EMPTY;
        end
      end
      default: begin
        status_d = STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(MAX_CAPACITY);
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cap_d;
      end
      if (cnt_inc) begin
        cnt_q[idx] <= cnt_cur + CNT_W'(1);
      end else if (cnt_dec) begin
        cnt_q[idx] <= cnt_cur - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_e'(op_i);
      sel_q <= sel_i;
      val_q <= val_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_hit_q <= rd_hit_d;
    end
    if (cmd_i.load_out) begin
      out_data_q   <= rd_hit_q ? VAL_W'(rdata_q) : '0;
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= DATA_WIDTH'(val_q);
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign read_value_o = out_data_q;
  assign status_o     = out_status_q;

  `MSSA_ASSERT(a_cnt_bound, clk_i, rst_ni, (cmd_i.exec && sel_ok) |-> (int'(cnt_cur) <= MAX_CAPACITY), "Fill count exceeds the maximum capacity.")
  `MSSA_ASSERT(a_bad_push, clk_i, rst_ni, (cmd_i.exec && (op_q == OP_PUSH) && !sel_ok) |=> (status_q == STAT_FULL), "Push to a missing stack was not refused.")
  `MSSA_ASSERT_NEVER(a_rw_both, clk_i, rst_ni, wr_en && rd_en, "Entry memory written and read in one cycle.")

endmodule

>>> sv/mssa_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-stack controller
// Sequences each transaction through accept, memory access and result load,
// and owns the handshake of both stream sides.
// ----------------------------------------------------------------------------
`include "multi_stack_shared_array_unit_assert.svh"

module mssa_ctrl
  import mssa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.load_out = (state_q == S_RESP) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `MSSA_ASSERT(a_accept_exec, clk_i, rst_ni,
               (in_valid_i && in_ready_o) |=> (state_q == S_EXEC),
               "Accepted transaction did not reach the access step.")
  `MSSA_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                     cmd_o.load_out && out_valid_q && !out_ready_i,
                     "Pending result overwritten.")
  `MSSA_ASSERT(a_out_hold, clk_i, rst_ni,
               (out_valid_o && !out_ready_i) |=> out_valid_o,
               "Pending result dropped before it was taken.")

endmodule

>>> sv/multi_stack_shared_array_unit.sv
// ----------------------------------------------------------------------------
// Multi-stack shared array unit
// Several fixed-capacity stacks in one shared entry memory. Each transaction
// pushes, pops or peeks one stack and yields one result. An accepted
// transaction passes through three steps (input register, memory access,
// result load), and a new transaction is accepted only after the current
// one has finished its result load; the single-port entry memory access
// depends on the stack's fill count. Input is refused while a result waits
// behind an earlier one that has not been taken.
// ----------------------------------------------------------------------------
module multi_stack_shared_array_unit
  import mssa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,   // stack_capacity
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VAL_W-1:0]    s_axis_tdata, // push_value
  input  logic [3:0]          s_axis_tuser, // operation, stack_select
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [VAL_W-1:0]    m_axis_tdata, // read_value
  output logic [STATUS_W-1:0] m_axis_tuser  // status_code
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  mssa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mssa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_valid_i  (cfg_valid),
    .cfg_data_i   (cfg_data),
    .op_i         (s_axis_tuser[1:0]),
    .sel_i        (s_axis_tuser[3:2]),
    .val_i        (s_axis_tdata),
    .read_value_o (m_axis_tdata),
    .status_o     (m_axis_tuser)
  );

endmodule
